/* rtl/core/f2d_pkg.sv */
// ----------------------------------------------------------------------------
// f2d_pkg
// Shared constants, types and unit controls of the float to decimal text core.
// ----------------------------------------------------------------------------
package f2d_pkg;

   localparam int MAX_FRAC_DIGITS = 16;
   localparam int FRAC_CNT_W      = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int CFG_W           = 5;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam int FLOAT_W    = 32;
   localparam int EXP_W      = 8;
   localparam int MANT_W     = 24;
   localparam int FRAC_W     = 24;
   localparam int INT_W      = 31;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int STEP_CNT_W = $clog2(INT_W + 1);
   localparam int DIG_CNT_W  = $clog2(BCD_DIGITS + 1);
   localparam int SHIFT_W    = 5;

   localparam int EXP_BIAS      = 127;
   localparam int EXP_TOO_LARGE = EXP_BIAS + 31;
   localparam int EXP_INT_ALL   = EXP_BIAS + 23;
   localparam int EXP_TINY      = EXP_BIAS - 23;
   localparam int EXP_SPECIAL   = 255;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_POINT = 8'h2e;
   localparam logic [7:0] CH_NONE  = 8'h00;

   typedef enum logic [1:0] {
      BCD_NOP   = 2'd0,
      BCD_LOAD  = 2'd1,
      BCD_SHIFT = 2'd2
   } bcd_op_type;

   typedef enum logic [1:0] {
      FRAC_NOP  = 2'd0,
      FRAC_LOAD = 2'd1,
      FRAC_STEP = 2'd2
   } frac_op_type;

   typedef struct packed {
      logic       busy;
      logic [3:0] top_digit;
   } bcd_stat_type;

endpackage

/* rtl/core/f2d_bcd.sv */
// ----------------------------------------------------------------------------
// f2d_bcd
// Iterative binary to BCD converter (shift and add three) with a digit
// shift-out path for most-significant-first emission.
// ----------------------------------------------------------------------------
module f2d_bcd (
   input  logic                        clock,
   input  logic                        reset,
   input  f2d_pkg::bcd_op_type         op,
   input  logic [f2d_pkg::INT_W-1:0]   load_value,
   output f2d_pkg::bcd_stat_type       stat
);
   import f2d_pkg::*;

   logic [INT_W-1:0]      bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BCD_W-1:0]      adj;

   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                     : bcd_ff[4*d +: 4];
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (op == BCD_LOAD) begin
         bin_in = load_value;
         bcd_in = '0;
         cnt_in = STEP_CNT_W'(INT_W);
      end else if (cnt_ff != '0) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[INT_W-1]};
         bin_in = {bin_ff[INT_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
      end else if (op == BCD_SHIFT) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.busy      = (cnt_ff != '0);
   assign stat.top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

/* rtl/core/f2d_frac.sv */
// ----------------------------------------------------------------------------
// f2d_frac
// Binary fraction register that yields one truncated decimal digit per step
// by multiplying by ten with a shift-and-add.
// ----------------------------------------------------------------------------
module f2d_frac (
   input  logic                         clock,
   input  f2d_pkg::frac_op_type         op,
   input  logic [f2d_pkg::FRAC_W-1:0]   load_value,
   output logic [3:0]                   digit
);
   import f2d_pkg::*;

   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [FRAC_W+3:0] prod;

   assign prod  = {frac_ff, 3'b000} + {2'b00, frac_ff, 1'b0};
   assign digit = prod[FRAC_W+3 -: 4];

   always_comb begin
      case (op)
         FRAC_LOAD: frac_in = load_value;
         FRAC_STEP: frac_in = prod[FRAC_W-1:0];
         default:   frac_in = frac_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      frac_ff <= frac_in;
   end

endmodule

/* rtl/core/float_to_decimal_text_core.sv */
// ----------------------------------------------------------------------------
// float_to_decimal_text_core
// Converts an IEEE single-precision word into ASCII decimal text.
// ----------------------------------------------------------------------------
// The req channel takes one 32-bit float word per beat. The rsp channel
// returns the text one character per beat: an optional '-', the integer
// digits, '.', and frac_digits truncated fractional digits (saturated at 16).
// The final beat of a word has rsp_last_char set. A word with exponent of 31
// or more, other than a negative NaN, gives a single beat with rsp_too_large
// set and a zero character. The integer part goes through a
// shift-and-add-three converter that shifts in the 31 integer bits, then the
// ten BCD digits are shifted out one per cycle while the output is not
// stalled (leading zeros are dropped without a beat), and each fractional
// digit takes one times-ten step. req_ready is high only while no word is in
// work. A stalled receiver holds the current beat in the output register and
// the sequencer waits. Synchronous reset returns to idle with the output
// empty and frac_digits at 6.
// ----------------------------------------------------------------------------
module float_to_decimal_text_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [f2d_pkg::FLOAT_W-1:0]     req_float_bits,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_char_code,
   output logic                            rsp_last_char,
   output logic                            rsp_too_large,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [f2d_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [f2d_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [f2d_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import f2d_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ERR   = 6'b000010,
      S_CONV  = 6'b000100,
      S_SIGN  = 6'b001000,
      S_INT   = 6'b010000,
      S_POINT = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic                  frac_phase_ff, frac_phase_in;
   logic [CFG_W-1:0]      frac_digits_ff;
   logic                  neg_ff, neg_in;
   logic                  started_ff, started_in;
   logic [DIG_CNT_W-1:0]  icnt_ff, icnt_in;
   logic [FRAC_CNT_W-1:0] fcnt_ff, fcnt_in;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_char_ff;
   logic                  rsp_last_ff, rsp_err_ff;

   logic                  slot_free, emit, emit_last, emit_err;
   logic [7:0]            emit_char;
   bcd_op_type            bcd_op;
   frac_op_type           frac_op;
   bcd_stat_type          bcd_stat;
   logic [3:0]            frac_digit;

   logic                  d_sign, d_negative, d_zero_like, d_too_large;
   logic [EXP_W-1:0]      d_exp;
   logic [MANT_W-1:0]     d_mant;
   logic [INT_W-1:0]      d_ipart;
   logic [FRAC_W-1:0]     d_frac;
   logic [FRAC_CNT_W-1:0] nd;
   logic                  csr_write;

   // Input word decode into integer and fraction parts.
   always_comb begin
      d_sign      = req_float_bits[FLOAT_W-1];
      d_exp       = req_float_bits[FLOAT_W-2 -: EXP_W];
      d_mant      = {1'b1, req_float_bits[MANT_W-2:0]};
      d_negative  = d_sign && (req_float_bits[FLOAT_W-2:0] != '0) &&
                    !((d_exp == EXP_W'(EXP_SPECIAL)) && (req_float_bits[MANT_W-2:0] != '0));
      d_zero_like = d_sign && !d_negative;
      d_too_large = !d_zero_like && (d_exp >= EXP_W'(EXP_TOO_LARGE));
      d_ipart     = '0;
      d_frac      = '0;
      if (d_zero_like || (d_exp < EXP_W'(EXP_TINY))) begin
         d_ipart = '0;
      end else if (d_exp >= EXP_W'(EXP_INT_ALL)) begin
         d_ipart = INT_W'({{(INT_W-MANT_W){1'b0}}, d_mant}
                   << SHIFT_W'(d_exp - EXP_W'(EXP_INT_ALL)));
      end else if (d_exp >= EXP_W'(EXP_BIAS)) begin
         d_ipart = INT_W'(d_mant >> SHIFT_W'(EXP_W'(EXP_INT_ALL) - d_exp));
         d_frac  = FRAC_W'({{MANT_W{1'b0}}, d_mant}
                   << SHIFT_W'(d_exp - EXP_W'(EXP_BIAS - 1)));
      end else begin
         d_frac  = d_mant >> SHIFT_W'(EXP_W'(EXP_BIAS - 1) - d_exp);
      end
   end

   always_comb begin
      if (int'(frac_digits_ff) > MAX_FRAC_DIGITS) begin
         nd = FRAC_CNT_W'(MAX_FRAC_DIGITS);
      end else begin
         nd = FRAC_CNT_W'(frac_digits_ff);
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      frac_phase_in = frac_phase_ff;
      neg_in        = neg_ff;
      started_in    = started_ff;
      icnt_in       = icnt_ff;
      fcnt_in       = fcnt_ff;
      emit          = 1'b0;
      emit_char     = CH_NONE;
      emit_last     = 1'b0;
      emit_err      = 1'b0;
      bcd_op        = BCD_NOP;
      frac_op       = FRAC_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (d_too_large) begin
                  state_in = S_ERR;
               end else begin
                  state_in = S_CONV;
                  bcd_op   = BCD_LOAD;
                  frac_op  = FRAC_LOAD;
                  neg_in   = d_negative;
                  fcnt_in  = nd;
               end
            end
         end
         S_ERR: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               emit_err  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_CONV: begin
            if (!bcd_stat.busy) begin
               state_in   = neg_ff ? S_SIGN : S_INT;
               icnt_in    = DIG_CNT_W'(BCD_DIGITS);
               started_in = 1'b0;
            end
         end
         S_SIGN: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = CH_MINUS;
               state_in  = S_INT;
            end
         end
         S_INT: begin
            if (!started_ff && (bcd_stat.top_digit == 4'd0) && (icnt_ff != DIG_CNT_W'(1))) begin
               bcd_op  = BCD_SHIFT;
               icnt_in = icnt_ff - 1'b1;
            end else if (slot_free) begin
               emit       = 1'b1;
               emit_char  = CH_ZERO + {4'd0, bcd_stat.top_digit};
               bcd_op     = BCD_SHIFT;
               started_in = 1'b1;
               icnt_in    = icnt_ff - 1'b1;
               if (icnt_ff == DIG_CNT_W'(1)) begin
                  state_in      = S_POINT;
                  frac_phase_in = 1'b0;
               end
            end
         end
         S_POINT: begin
            if (slot_free) begin
               emit = 1'b1;
               if (!frac_phase_ff) begin
                  emit_char = CH_POINT;
                  emit_last = (fcnt_ff == '0);
                  if (fcnt_ff == '0) begin
                     state_in = S_IDLE;
                  end else begin
                     frac_phase_in = 1'b1;
                  end
               end else begin
                  emit_char = CH_ZERO + {4'd0, frac_digit};
                  frac_op   = FRAC_STEP;
                  fcnt_in   = fcnt_ff - 1'b1;
                  emit_last = (fcnt_ff == FRAC_CNT_W'(1));
                  if (fcnt_ff == FRAC_CNT_W'(1)) begin
                     state_in      = S_IDLE;
                     frac_phase_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         frac_phase_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         started_ff    <= 1'b0;
         neg_ff        <= 1'b0;
         icnt_ff       <= '0;
         fcnt_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         frac_phase_ff <= frac_phase_in;
         started_ff    <= started_in;
         neg_ff        <= neg_in;
         icnt_ff       <= icnt_in;
         fcnt_ff       <= fcnt_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit) begin
         rsp_char_ff <= emit_char;
         rsp_last_ff <= emit_last;
         rsp_err_ff  <= emit_err;
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_digits_ff <= CFG_W'(6);
      end else if (csr_write && (csr_paddr[CSR_ADDR_W-1] == 1'b0)) begin
         frac_digits_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == 1'b0)
                       ? {{(CSR_DATA_W-CFG_W){1'b0}}, frac_digits_ff} : '0;
   assign csr_pready = 1'b1;

   f2d_bcd u_bcd (
      .clock      (clock),
      .reset      (reset),
      .op         (bcd_op),
      .load_value (d_ipart),
      .stat       (bcd_stat)
   );

   f2d_frac u_frac (
      .clock      (clock),
      .op         (frac_op),
      .load_value (d_frac),
      .digit      (frac_digit)
   );

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
   assign rsp_too_large = rsp_err_ff;

endmodule

/* rtl/core/f2d_check.sv */
// ----------------------------------------------------------------------------
// f2d_check
// Port-level checks for the float to decimal text core, bound to the top.
// ----------------------------------------------------------------------------
module f2d_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char_code,
   input logic       rsp_last_char,
   input logic       rsp_too_large
);

   // An error beat is always the sole beat of its word.
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_large |-> rsp_last_char && (rsp_char_code == 8'h00))
      else $error("error beat without last flag or with a character");

   // A stalled beat keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code)
                                  && $stable(rsp_last_char))
      else $error("stalled beat changed");

   // Once a word is taken, req_ready is low in the following cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // Reset empties the output register.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind float_to_decimal_text_core f2d_check u_f2d_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_char_code (rsp_char_code),
   .rsp_last_char (rsp_last_char),
   .rsp_too_large (rsp_too_large)
);
